// ===== sv/mzncc_pkg.sv =====
package mzncc_pkg;

  localparam int SCORE_FRAC_BITS = 16;
  localparam int SCORE_BITS      = SCORE_FRAC_BITS + 2;

  typedef struct packed {
    logic [7:0] pixel_one;
    logic [7:0] pixel_two;
    logic       in_mask;
    logic       last_pixel;
  } in_t;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score;
    logic                         undefined;
  } out_t;

endpackage

// ===== sv/mzncc_fifo.sv =====
module mzncc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/mzncc_front.sv =====
module mzncc_front
  import mzncc_pkg::*;
#(
  parameter int MAX_PIXELS = 65536,
  parameter int CW = 17,
  parameter int SW = CW + 8,
  parameter int QW = CW + 16,
  parameter int EW = CW + 2 * SW + 3 * QW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_t           in_data,
  output logic          push,
  output logic [EW-1:0] push_data,
  input  logic          queue_full
);

  logic [CW-1:0] pixel_count, pixel_count_next;
  logic [SW-1:0] sum_one, sum_one_next;
  logic [SW-1:0] sum_two, sum_two_next;
  logic [QW-1:0] sumsq_one, sumsq_one_next;
  logic [QW-1:0] sumsq_two, sumsq_two_next;
  logic [QW-1:0] cross_sum, cross_sum_next;
  logic [15:0]   sq_one, sq_two, prod_x;
  logic          accept;
  logic          take;

  assign in_ready = ~queue_full;
  assign accept   = in_valid & in_ready;
  assign take     = in_data.in_mask & (pixel_count < CW'(MAX_PIXELS));
  assign push     = accept & in_data.last_pixel;

  assign sq_one = in_data.pixel_one * in_data.pixel_one;
  assign sq_two = in_data.pixel_two * in_data.pixel_two;
  assign prod_x = in_data.pixel_one * in_data.pixel_two;

  always_comb begin
    pixel_count_next = pixel_count;
    sum_one_next     = sum_one;
    sum_two_next     = sum_two;
    sumsq_one_next   = sumsq_one;
    sumsq_two_next   = sumsq_two;
    cross_sum_next   = cross_sum;
    if (take) begin
      pixel_count_next = pixel_count + CW'(1);
      sum_one_next     = sum_one + SW'(in_data.pixel_one);
      sum_two_next     = sum_two + SW'(in_data.pixel_two);
      sumsq_one_next   = sumsq_one + QW'(sq_one);
      sumsq_two_next   = sumsq_two + QW'(sq_two);
      cross_sum_next   = cross_sum + QW'(prod_x);
    end
  end

  assign push_data = {pixel_count_next, sum_one_next, sum_two_next,
                      sumsq_one_next, sumsq_two_next, cross_sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= '0;
      sum_one     <= '0;
      sum_two     <= '0;
      sumsq_one   <= '0;
      sumsq_two   <= '0;
      cross_sum   <= '0;
    end else if (accept) begin
      if (in_data.last_pixel) begin
        pixel_count <= '0;
        sum_one     <= '0;
        sum_two     <= '0;
        sumsq_one   <= '0;
        sumsq_two   <= '0;
        cross_sum   <= '0;
      end else begin
        pixel_count <= pixel_count_next;
        sum_one     <= sum_one_next;
        sum_two     <= sum_two_next;
        sumsq_one   <= sumsq_one_next;
        sumsq_two   <= sumsq_two_next;
        cross_sum   <= cross_sum_next;
      end
    end
  end

endmodule

// ===== sv/mzncc_back.sv =====
module mzncc_back
  import mzncc_pkg::*;
#(
  parameter int CW = 17,
  parameter int SW = CW + 8,
  parameter int QW = CW + 16,
  parameter int EW = CW + 2 * SW + 3 * QW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  logic [EW-1:0] job_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output out_t          out_data
);

  localparam int DW   = 2 * CW + 16;
  localparam int PW   = 2 * DW;
  localparam int NCH  = (DW + 15) / 16;
  localparam int MBW  = NCH * 16;
  localparam int F    = SCORE_FRAC_BITS;
  localparam int DIVN = 2 * F + 2;
  localparam int SQN  = F + 2;
  localparam int VW   = 2 * F + 4;
  localparam int RTW  = F + 2;
  localparam int RW   = F + 5;
  localparam int NW   = $clog2(DIVN + 1);

  typedef struct packed {
    logic [CW-1:0] n;
    logic [SW-1:0] s1;
    logic [SW-1:0] s2;
    logic [QW-1:0] sq1;
    logic [QW-1:0] sq2;
    logic [QW-1:0] cr;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LOAD, B_MUL, B_STORE, B_DIV, B_SQRT, B_FIN, B_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NSQ1, OP_SS1, OP_NSQ2, OP_SS2, OP_NCR, OP_S12, OP_VAR, OP_NUM
  } op_t;

  state_t         state;
  op_t            op;
  job_t           job;
  logic [DW-1:0]  ma;
  logic [MBW-1:0] mb;
  logic [PW-1:0]  macc, macc_step;
  logic [DW-1:0]  ta, d1, d2, mag;
  logic           neg;
  logic [PW-1:0]  pv;
  logic [PW-1:0]  rmd;
  logic [PW:0]    r2;
  logic           qbit;
  logic [VW-1:0]  qv;
  logic [RW-1:0]  rem, rem2, trial;
  logic [RTW-1:0] root;
  logic [RTW:0]   root_inc;
  logic [NW-1:0]  cnt;
  logic [DW-1:0]  lo;
  logic           q0;

  assign pop       = (state == B_IDLE) & job_valid;
  assign macc_step = (macc << 16) + PW'({16'd0, ma} * mb[MBW-1 -: 16]);
  assign lo        = macc[DW-1:0];
  assign q0        = macc >= pv;
  assign r2        = {rmd, 1'b0};
  assign qbit      = r2 >= {1'b0, pv};
  assign rem2      = {rem[RW-3:0], qv[VW-1 -: 2]};
  assign trial     = RW'({root, 2'b01});
  assign root_inc  = {1'b0, root} + (RTW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            job   <= job_t'(job_data);
            op    <= OP_NSQ1;
            state <= B_LOAD;
          end
        end
        B_LOAD: begin
          case (op)
            OP_NSQ1: begin ma <= DW'(job.n);  mb <= MBW'(job.sq1); end
            OP_SS1:  begin ma <= DW'(job.s1); mb <= MBW'(job.s1);  end
            OP_NSQ2: begin ma <= DW'(job.n);  mb <= MBW'(job.sq2); end
            OP_SS2:  begin ma <= DW'(job.s2); mb <= MBW'(job.s2);  end
            OP_NCR:  begin ma <= DW'(job.n);  mb <= MBW'(job.cr);  end
            OP_S12:  begin ma <= DW'(job.s1); mb <= MBW'(job.s2);  end
            OP_VAR:  begin ma <= d1;          mb <= MBW'(d2);      end
            OP_NUM:  begin ma <= mag;         mb <= MBW'(mag);     end
            default: begin ma <= '0;          mb <= '0;            end
          endcase
          macc  <= '0;
          cnt   <= '0;
          state <= B_MUL;
        end
        B_MUL: begin
          // most significant chunk first
          macc <= macc_step;
          mb   <= mb << 16;
          cnt  <= cnt + NW'(1);
          if (cnt == NW'(NCH - 1)) begin
            state <= B_STORE;
          end
        end
        B_STORE: begin
          case (op)
            OP_NSQ1: begin ta <= lo; op <= OP_SS1; state <= B_LOAD; end
            OP_SS1: begin
              d1    <= (ta > lo) ? ta - lo : '0;
              op    <= OP_NSQ2;
              state <= B_LOAD;
            end
            OP_NSQ2: begin ta <= lo; op <= OP_SS2; state <= B_LOAD; end
            OP_SS2: begin
              d2    <= (ta > lo) ? ta - lo : '0;
              op    <= OP_NCR;
              state <= B_LOAD;
            end
            OP_NCR:  begin ta <= lo; op <= OP_S12; state <= B_LOAD; end
            OP_S12: begin
              neg <= lo > ta;
              mag <= (lo > ta) ? lo - ta : ta - lo;
              if (job.n == '0 || d1 == '0 || d2 == '0) begin
                out_data.score     <= '0;
                out_data.undefined <= 1'b1;
                out_valid          <= 1'b1;
                state              <= B_OUT;
              end else begin
                op    <= OP_VAR;
                state <= B_LOAD;
              end
            end
            OP_VAR: begin pv <= macc; op <= OP_NUM; state <= B_LOAD; end
            default: begin
              // integer part of num^2 / var product is 0 or 1
              rmd   <= q0 ? macc - pv : macc;
              qv    <= VW'(q0);
              cnt   <= '0;
              state <= B_DIV;
            end
          endcase
        end
        B_DIV: begin
          rmd <= qbit ? PW'(r2 - {1'b0, pv}) : r2[PW-1:0];
          qv  <= {qv[VW-2:0], qbit};
          if (cnt == NW'(DIVN - 1)) begin
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= B_SQRT;
          end else begin
            cnt <= cnt + NW'(1);
          end
        end
        B_SQRT: begin
          if (rem2 >= trial) begin
            rem  <= rem2 - trial;
            root <= {root[RTW-2:0], 1'b1};
          end else begin
            rem  <= rem2;
            root <= {root[RTW-2:0], 1'b0};
          end
          qv  <= qv << 2;
          cnt <= cnt + NW'(1);
          if (cnt == NW'(SQN - 1)) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          // largest q with 2q-1 <= isqrt
          out_data.score     <= neg ? -SCORE_BITS'(root_inc[RTW:1])
                                    :  SCORE_BITS'(root_inc[RTW:1]);
          out_data.undefined <= 1'b0;
          out_valid          <= 1'b1;
          state              <= B_OUT;
        end
        B_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/masked_zncc_score.sv =====
// Masked zero-mean normalized cross-correlation of two 8-bit patches. Pixel
// pairs are taken one per cycle; a pair marked last closes the patch and
// yields one request for the scoring unit, which returns a Q1.16 score
// (ties rounded away from zero) or an undefined flag. Accumulation never
// stalls while the two-entry job queue has room. Each defined score keeps
// the scoring unit busy until the result is taken; it passes through the
// shared 16-bit-chunk multiplier, the bit-serial divider and the bit-serial
// square root, while an undefined result skips the divider and square root.
module masked_zncc_score
  import mzncc_pkg::*;
#(
  parameter int MAX_PIXELS = 65536
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int SW = CW + 8;
  localparam int QW = CW + 16;
  localparam int EW = CW + 2 * SW + 3 * QW;

  logic          push, full, pop, not_empty;
  logic [EW-1:0] push_data, pop_data;

  mzncc_front #(
    .MAX_PIXELS(MAX_PIXELS), .CW(CW), .SW(SW), .QW(QW), .EW(EW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_data  (push_data),
    .queue_full (full)
  );

  mzncc_fifo #(.WIDTH(EW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  mzncc_back #(.CW(CW), .SW(SW), .QW(QW), .EW(EW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (not_empty),
    .job_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/mzncc_check.sv =====
module mzncc_check
  import mzncc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  localparam logic signed [SCORE_BITS-1:0] ONE = SCORE_BITS'(1 << SCORE_FRAC_BITS);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.undefined |-> out_data.score == '0)
    else $error("undefined result with nonzero score");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.score <= ONE && out_data.score >= -ONE)
    else $error("score outside unit range");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind masked_zncc_score mzncc_check u_check (.*);
